/* hdl/grid_raycast_column_top_defines.svh */
// Assertion macros used by the grid ray caster execution part
`ifndef GRID_RAYCAST_COLUMN_TOP_DEFINES_SVH
`define GRID_RAYCAST_COLUMN_TOP_DEFINES_SVH

// Check cons in the same cycle as ante
`define GRC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check cons in the cycle after ante
`define GRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/grc_pkg.sv */
// Types, constants and register codes of the grid ray caster
package grc_pkg;

  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int GRID_WIDTH    = 32;
  localparam int GRID_HEIGHT   = 32;
  localparam int MAP_DEPTH     = GRID_WIDTH * GRID_HEIGHT;
  localparam int MAP_AW        = $clog2(MAP_DEPTH);
  localparam int WALK_LIMIT    = 2 * (GRID_WIDTH + GRID_HEIGHT) + 160;
  localparam int WALK_W        = $clog2(WALK_LIMIT);
  localparam int HEIGHT_CAP    = 65535;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  localparam int PLANE_K = 24;
  localparam logic [31:0] PLANE_M =
    32'(((64'd1 << (17 + PLANE_K)) + 64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));

  localparam int DIV_NW = 47;
  localparam int DIV_DW = 35;
  localparam int DIV_CW = $clog2(DIV_NW + 1);

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  localparam logic [2:0] CFG_CAMERA_X    = 3'd0;
  localparam logic [2:0] CFG_CAMERA_Y    = 3'd1;
  localparam logic [2:0] CFG_VIEW_SINE   = 3'd2;
  localparam logic [2:0] CFG_VIEW_COSINE = 3'd3;
  localparam logic [2:0] CFG_HORIZON     = 3'd4;

  typedef struct packed {
    logic              is_cast;
    logic [9:0]        column;
    logic [MAP_AW-1:0] addr;
    logic              in_grid;
    logic [7:0]        value;
  } item_t;

  typedef struct packed {
    logic [20:0]        camera_x;
    logic [20:0]        camera_y;
    logic signed [15:0] view_sine;
    logic signed [15:0] view_cosine;
    logic signed [13:0] horizon;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [DIV_NW-1:0] dividend;
    logic [DIV_DW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_NW-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

/* hdl/grc_front.sv */
// Input stage: accepts beats and decodes them into queue items
module grc_front import grc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  logic      in_opcode,
  input  logic [9:0] in_column,
  input  logic [4:0] in_cell_x,
  input  logic [4:0] in_cell_y,
  input  logic [7:0] in_cell_value,
  input  logic      clearing,
  input  q_status_t q_stat,
  output logic      push,
  output item_t     push_item
);

  logic  held_r;
  item_t item_r;
  item_t dec;

  always_comb begin
    dec.is_cast = (in_opcode == OP_CAST);
    dec.column  = in_column;
    dec.addr    = MAP_AW'(MAP_AW'(in_cell_y) * MAP_AW'(GRID_WIDTH) + MAP_AW'(in_cell_x));
    dec.in_grid = (32'(in_cell_x) < GRID_WIDTH) && (32'(in_cell_y) < GRID_HEIGHT);
    dec.value   = in_cell_value;
  end

  assign push      = held_r && !q_stat.full;
  assign push_item = item_r;
  assign in_stall  = clearing || (held_r && q_stat.full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      held_r <= 1'b1;
    end else if (push) begin
      held_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= dec;
    end
  end

endmodule

/* hdl/grc_queue.sv */
// Short item queue between the front and back parts
module grc_queue import grc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  item_t     push_item,
  input  logic      pop,
  output item_t     head_item,
  output q_status_t q_stat
);

  item_t           slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wp_r;
  logic [Q_AW-1:0] rp_r;
  logic [Q_CW-1:0] cnt_r;

  assign head_item    = slot_r[rp_r];
  assign q_stat.full  = (cnt_r == Q_CW'(Q_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == Q_AW'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= push_item;
    end
  end

endmodule

/* hdl/grc_div.sv */
// Shared restoring divider, one quotient bit per cycle
module grc_div import grc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r;
  logic              done_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_DW-1:0] rem_r;
  logic [DIV_NW-1:0] quo_r;
  logic [DIV_DW-1:0] den_r;
  logic [DIV_DW:0]   shifted;
  logic              ge;

  assign shifted = {rem_r, quo_r[DIV_NW-1]};
  assign ge      = (shifted >= {1'b0, den_r});

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CW'(DIV_NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.dividend;
      den_r <= req.divisor;
    end else if (busy_r) begin
      rem_r <= ge ? DIV_DW'(shifted - {1'b0, den_r}) : DIV_DW'(shifted);
      quo_r <= {quo_r[DIV_NW-2:0], ge};
    end
  end

endmodule

/* hdl/grc_back.sv */
// Execution part: map store, ray setup, grid walk and span computation
`include "grid_raycast_column_top_defines.svh"
module grc_back import grc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  item_t            head_item,
  input  q_status_t        q_stat,
  output logic             pop,
  output logic             clearing,
  output div_req_t         div_req,
  input  div_rsp_t         div_rsp,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [9:0]       out_column_echo,
  output logic [8:0]       out_span_start,
  output logic [8:0]       out_span_end,
  output logic             out_hit_side,
  output logic             out_left_map,
  output logic [7:0]       out_wall_value,
  output logic signed [6:0] out_wall_x,
  output logic signed [6:0] out_wall_y,
  output logic [31:0]      out_perp_distance
);

  typedef enum logic [13:0] {
    S_CLEAR = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_PLANE = 14'b00000000000100,
    S_MUL   = 14'b00000000001000,
    S_DIR   = 14'b00000000010000,
    S_RX    = 14'b00000000100000,
    S_RY    = 14'b00000001000000,
    S_SIDE  = 14'b00000010000000,
    S_STEP  = 14'b00000100000000,
    S_CHECK = 14'b00001000000000,
    S_PERP  = 14'b00010000000000,
    S_HGT   = 14'b00100000000000,
    S_SPAN  = 14'b01000000000000,
    S_OUT   = 14'b10000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [7:0]        mem [MAP_DEPTH];
  logic [7:0]        rd_r;
  logic              mem_we;
  logic [MAP_AW-1:0] mem_wa;
  logic [7:0]        mem_wd;
  logic [MAP_AW-1:0] mem_ra;

  logic [MAP_AW-1:0] clr_cnt_r;
  logic              launched_r;
  logic              out_valid_r;

  logic [9:0]         col_r;
  logic signed [18:0] plane_r;
  logic signed [34:0] pa_r;
  logic signed [34:0] pb_r;
  logic signed [35:0] dirx_r;
  logic signed [35:0] diry_r;
  logic [31:0]        dlx_r;
  logic [31:0]        dly_r;
  logic [40:0]        sdx_r;
  logic [40:0]        sdy_r;
  logic signed [6:0]  mx_r;
  logic signed [6:0]  my_r;
  logic               stx_neg_r;
  logic               sty_neg_r;
  logic               side_r;
  logic               left_r;
  logic [7:0]         val_r;
  logic [WALK_W-1:0]  walk_r;
  logic [31:0]        perp_r;
  logic [15:0]        hgt_r;
  logic [8:0]         start_r;
  logic [8:0]         end_r;

  logic [DIV_DW-1:0]  absx;
  logic [DIV_DW-1:0]  absy;
  logic               div_zero;
  logic               div_state;
  logic               step_x;
  logic signed [6:0]  nmx;
  logic signed [6:0]  nmy;
  logic               off_map;
  logic [41:0]        plane_prod;
  logic [16:0]        distx;
  logic [16:0]        disty;
  logic [48:0]        prodx;
  logic [48:0]        prody;
  logic [40:0]        diff;
  logic signed [18:0] span_lo;
  logic signed [18:0] span_hi;
  logic               out_load;

  assign clearing  = (state_r == S_CLEAR);
  assign pop       = (state_r == S_IDLE) && !q_stat.empty;
  assign out_load  = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;

  // map store
  always_comb begin
    mem_we = clearing || (pop && !head_item.is_cast && head_item.in_grid);
    mem_wa = clearing ? clr_cnt_r : head_item.addr;
    mem_wd = clearing ? 8'd0 : head_item.value;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (state_r == S_STEP) begin
      rd_r <= mem[mem_ra];
    end
  end

  // divider operands
  assign absx = dirx_r[35] ? DIV_DW'(-dirx_r) : DIV_DW'(dirx_r);
  assign absy = diry_r[35] ? DIV_DW'(-diry_r) : DIV_DW'(diry_r);

  always_comb begin
    div_req.dividend = '0;
    div_req.divisor  = '0;
    div_zero         = 1'b0;
    div_state        = 1'b0;
    unique case (state_r)
      S_RX: begin
        div_state        = 1'b1;
        div_zero         = (dirx_r == '0);
        div_req.dividend = DIV_NW'(1) << 46;
        div_req.divisor  = absx;
      end
      S_RY: begin
        div_state        = 1'b1;
        div_zero         = (diry_r == '0);
        div_req.dividend = DIV_NW'(1) << 46;
        div_req.divisor  = absy;
      end
      S_HGT: begin
        div_state        = 1'b1;
        div_zero         = (perp_r == '0);
        div_req.dividend = DIV_NW'(SCREEN_HEIGHT) << 16;
        div_req.divisor  = DIV_DW'(perp_r);
      end
      default: begin
      end
    endcase
    div_req.start = div_state && !div_zero && !launched_r;
  end

  // walk step
  always_comb begin
    step_x  = (sdx_r < sdy_r);
    nmx     = mx_r;
    nmy     = my_r;
    if (step_x) begin
      nmx = stx_neg_r ? mx_r - 7'sd1 : mx_r + 7'sd1;
    end else begin
      nmy = sty_neg_r ? my_r - 7'sd1 : my_r + 7'sd1;
    end
    off_map = (nmx < 0) || (32'(nmx) >= GRID_WIDTH) || (nmy < 0) || (32'(nmy) >= GRID_HEIGHT);
    mem_ra  = MAP_AW'(MAP_AW'(unsigned'(nmy)) * MAP_AW'(GRID_WIDTH)
                      + MAP_AW'(unsigned'(nmx)));
  end

  // plane product, initial side distances, perpendicular difference and span bounds
  always_comb begin
    plane_prod = 42'(col_r) * 42'(PLANE_M);
    distx = dirx_r[35] ? {1'b0, cfg.camera_x[15:0]} : 17'(17'd65536 - cfg.camera_x[15:0]);
    disty = diry_r[35] ? {1'b0, cfg.camera_y[15:0]} : 17'(17'd65536 - cfg.camera_y[15:0]);
    prodx = distx * dlx_r;
    prody = disty * dly_r;
    diff  = side_r ? sdy_r - 41'(dly_r) : sdx_r - 41'(dlx_r);
    span_lo = 19'sd0 + 19'(SCREEN_HEIGHT / 2) - $signed({4'b0, hgt_r[15:1]}) + 19'(cfg.horizon);
    span_hi = 19'sd0 + 19'(SCREEN_HEIGHT / 2) + $signed({4'b0, hgt_r[15:1]}) + 19'(cfg.horizon);
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == MAP_AW'(MAP_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (pop && head_item.is_cast) state_nxt = S_PLANE;
      S_PLANE: state_nxt = S_MUL;
      S_MUL:   state_nxt = S_DIR;
      S_DIR:   state_nxt = S_RX;
      S_RX:    if (div_zero || div_rsp.done) state_nxt = S_RY;
      S_RY:    if (div_zero || div_rsp.done) state_nxt = S_SIDE;
      S_SIDE:  state_nxt = S_STEP;
      S_STEP:  state_nxt = off_map ? S_PERP : S_CHECK;
      S_CHECK: begin
        if (rd_r != 8'd0 || walk_r == WALK_W'(WALK_LIMIT - 1)) begin
          state_nxt = S_PERP;
        end else begin
          state_nxt = S_STEP;
        end
      end
      S_PERP:  state_nxt = S_HGT;
      S_HGT:   if (div_zero || div_rsp.done) state_nxt = S_SPAN;
      S_SPAN:  state_nxt = S_OUT;
      S_OUT:   if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      launched_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (clearing) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (div_req.start) begin
        launched_r <= 1'b1;
      end else if (div_rsp.done) begin
        launched_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        col_r <= head_item.column;
      end
      S_PLANE: begin
        plane_r <= $signed({1'b0, plane_prod[PLANE_K +: 18]}) - 19'sd65536;
      end
      S_MUL: begin
        pa_r <= 35'(plane_r) * 35'(cfg.view_cosine);
        pb_r <= 35'(plane_r) * 35'(cfg.view_sine);
      end
      S_DIR: begin
        dirx_r <= (36'(cfg.view_sine) <<< 16) - 36'(pa_r);
        diry_r <= 36'(pb_r) + (36'(cfg.view_cosine) <<< 16);
      end
      S_RX: begin
        if (div_zero) begin
          dlx_r <= SAT32;
        end else if (div_rsp.done) begin
          dlx_r <= (|div_rsp.quotient[DIV_NW-1:32]) ? SAT32 : div_rsp.quotient[31:0];
        end
      end
      S_RY: begin
        if (div_zero) begin
          dly_r <= SAT32;
        end else if (div_rsp.done) begin
          dly_r <= (|div_rsp.quotient[DIV_NW-1:32]) ? SAT32 : div_rsp.quotient[31:0];
        end
      end
      S_SIDE: begin
        sdx_r     <= 41'(prodx >> 16);
        sdy_r     <= 41'(prody >> 16);
        stx_neg_r <= dirx_r[35];
        sty_neg_r <= diry_r[35];
        mx_r      <= $signed({2'b00, cfg.camera_x[20:16]});
        my_r      <= $signed({2'b00, cfg.camera_y[20:16]});
        side_r    <= 1'b0;
        left_r    <= 1'b1;
        val_r     <= 8'd0;
        walk_r    <= '0;
      end
      S_STEP: begin
        mx_r <= nmx;
        my_r <= nmy;
        if (step_x) begin
          sdx_r  <= sdx_r + 41'(dlx_r);
          side_r <= 1'b0;
        end else begin
          sdy_r  <= sdy_r + 41'(dly_r);
          side_r <= 1'b1;
        end
      end
      S_CHECK: begin
        walk_r <= walk_r + 1'b1;
        if (rd_r != 8'd0) begin
          left_r <= 1'b0;
          val_r  <= rd_r;
        end
      end
      S_PERP: begin
        perp_r <= (|diff[40:32]) ? SAT32 : diff[31:0];
      end
      S_HGT: begin
        if (div_zero) begin
          hgt_r <= 16'(HEIGHT_CAP);
        end else if (div_rsp.done) begin
          hgt_r <= (|div_rsp.quotient[DIV_NW-1:16]) ? 16'(HEIGHT_CAP)
                                                     : div_rsp.quotient[15:0];
        end
      end
      S_SPAN: begin
        start_r <= (span_lo < 0) ? 9'd0 :
                   (span_lo > 19'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT) : span_lo[8:0];
        end_r   <= (span_hi < 0) ? 9'd0 :
                   (span_hi > 19'(SCREEN_HEIGHT)) ? 9'(SCREEN_HEIGHT) : span_hi[8:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_column_echo   <= col_r;
      out_span_start    <= start_r;
      out_span_end      <= end_r;
      out_hit_side      <= side_r;
      out_left_map      <= left_r;
      out_wall_value    <= val_r;
      out_wall_x        <= mx_r;
      out_wall_y        <= my_r;
      out_perp_distance <= perp_r;
    end
  end

  `GRC_ASSERT_NOW(a_no_pop_in_clear, state_r == S_CLEAR, !pop, "item taken during map clear")
  `GRC_ASSERT_NOW(a_div_free, div_req.start, !div_rsp.busy, "divider started while busy")
  `GRC_ASSERT_NEXT(a_walk_limit, state_r == S_CHECK && rd_r == 8'd0 && walk_r == WALK_W'(WALK_LIMIT - 1), state_r == S_PERP, "walk ran past its step limit")

endmodule

/* hdl/grid_raycast_column_top.sv */
// Top level of the grid ray caster: configuration registers and part wiring
// Usage:
//   Input channel (in_*): each beat is a map write (opcode 0: cell_x, cell_y,
//   cell_value) or a column cast (opcode 1: column). Writes give no result;
//   each cast gives one beat on the result channel (out_*).
//   A beat moves when valid is high and stall is low.
//   Configuration (cfg_*): write cfg_wdata to register cfg_index while the
//   block is idle; unknown indexes are dropped.
//   Cast flow: from acceptance to its result beat, a cast runs ray setup, a
//   walk of up to 288 grid cells and the span computation. The shared
//   one-bit-per-cycle divider does three divisions (two reciprocals, wall
//   height), each skipped when its divisor is zero; each walk step passes the
//   STEP and CHECK states for the map RAM read. A map write is done in the
//   execution part as its item is popped. Casts are done one at a time.
//   Reset: rst_n low restores the register defaults; then all 1024 map cells
//   are cleared, with in_stall high meanwhile.
//   Output stall: a result holds in the output register; the input side keeps
//   filling the two-entry queue and front register until they are full.
module grid_raycast_column_top import grc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_opcode,
  input  logic [9:0]        in_column,
  input  logic [4:0]        in_cell_x,
  input  logic [4:0]        in_cell_y,
  input  logic [7:0]        in_cell_value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [9:0]        out_column_echo,
  output logic [8:0]        out_span_start,
  output logic [8:0]        out_span_end,
  output logic              out_hit_side,
  output logic              out_left_map,
  output logic [7:0]        out_wall_value,
  output logic signed [6:0] out_wall_x,
  output logic signed [6:0] out_wall_y,
  output logic [31:0]       out_perp_distance,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [20:0]       cfg_wdata
);

  cfg_t      cfg_r;
  q_status_t q_stat;
  item_t     push_item;
  item_t     head_item;
  logic      push;
  logic      pop;
  logic      clearing;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.camera_x    <= 21'd1048576;
      cfg_r.camera_y    <= 21'd1048576;
      cfg_r.view_sine   <= 16'sd0;
      cfg_r.view_cosine <= 16'sd16384;
      cfg_r.horizon     <= 14'sd0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CAMERA_X:    cfg_r.camera_x    <= cfg_wdata;
        CFG_CAMERA_Y:    cfg_r.camera_y    <= cfg_wdata;
        CFG_VIEW_SINE:   cfg_r.view_sine   <= $signed(cfg_wdata[15:0]);
        CFG_VIEW_COSINE: cfg_r.view_cosine <= $signed(cfg_wdata[15:0]);
        CFG_HORIZON:     cfg_r.horizon     <= $signed(cfg_wdata[13:0]);
        default: begin
        end
      endcase
    end
  end

  grc_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_column     (in_column),
    .in_cell_x     (in_cell_x),
    .in_cell_y     (in_cell_y),
    .in_cell_value (in_cell_value),
    .clearing      (clearing),
    .q_stat        (q_stat),
    .push          (push),
    .push_item     (push_item)
  );

  grc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head_item (head_item),
    .q_stat    (q_stat)
  );

  grc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  grc_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_item         (head_item),
    .q_stat            (q_stat),
    .pop               (pop),
    .clearing          (clearing),
    .div_req           (div_req),
    .div_rsp           (div_rsp),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_column_echo   (out_column_echo),
    .out_span_start    (out_span_start),
    .out_span_end      (out_span_end),
    .out_hit_side      (out_hit_side),
    .out_left_map      (out_left_map),
    .out_wall_value    (out_wall_value),
    .out_wall_x        (out_wall_x),
    .out_wall_y        (out_wall_y),
    .out_perp_distance (out_perp_distance)
  );

endmodule

/* sim/grid_raycast_column_top_tb.sv */
// Self-checking testbench of the grid ray caster: directed table, configuration cases, then random casts and writes
`timescale 1ns / 100ps

module grid_raycast_column_top_tb import grc_pkg::*;;

  typedef struct {
    logic [9:0]        column;
    logic [8:0]        span_start;
    logic [8:0]        span_end;
    logic              hit_side;
    logic              left_map;
    logic [7:0]        wall_value;
    logic signed [6:0] wall_x;
    logic signed [6:0] wall_y;
    logic [31:0]       perp;
  } column_hit_t;

  typedef struct {
    logic       opcode;
    logic [9:0] column;
    logic [4:0] cx;
    logic [4:0] cy;
    logic [7:0] value;
    logic       typed;
    logic [8:0] span_start;
    logic [8:0] span_end;
  } beat_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_opcode = 1'b0;
  logic [9:0] in_column = '0;
  logic [4:0] in_cell_x = '0;
  logic [4:0] in_cell_y = '0;
  logic [7:0] in_cell_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [9:0] out_column_echo;
  logic [8:0] out_span_start;
  logic [8:0] out_span_end;
  logic out_hit_side;
  logic out_left_map;
  logic [7:0] out_wall_value;
  logic signed [6:0] out_wall_x;
  logic signed [6:0] out_wall_y;
  logic [31:0] out_perp_distance;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [20:0] cfg_wdata = '0;

  grid_raycast_column_top u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0] grid_cells [MAP_DEPTH];
  logic [20:0] cam_x, cam_y;
  logic signed [15:0] sine_q, cosine_q;
  logic signed [13:0] horizon_q;
  column_hit_t expected_hits [$];
  logic [8:0] typed_start [$];
  logic [8:0] typed_end [$];
  logic typed_flag [$];
  int failures = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit quiet = 1'b0;
  bit sink_active = 1'b0;

  function automatic logic [63:0] recip_delta(longint d);
    longint unsigned a, q;
    a = (d < 0) ? -d : d;
    if (a == 0) return 64'hFFFF_FFFF;
    q = (64'd1 << 46) / a;
    return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
  endfunction

  function automatic int clamp_row(longint v);
    if (v < 0) return 0;
    if (v > SCREEN_HEIGHT) return SCREEN_HEIGHT;
    return int'(v);
  endfunction

  function automatic column_hit_t cast_column(logic [9:0] col);
    column_hit_t r;
    longint plane, dirx, diry, mx, my, stx, sty, half;
    longint unsigned dlx, dly, sdx, sdy, frx, fry, perp, height;
    int side;
    bit left;
    logic [7:0] val;
    side = 0;
    left = 1'b1;
    val = '0;
    plane = longint'((longint'(col) * 131072) / SCREEN_WIDTH) - 65536;
    dirx = longint'(sine_q) * 65536 - plane * longint'(cosine_q);
    diry = plane * longint'(sine_q) + longint'(cosine_q) * 65536;
    dlx = recip_delta(dirx);
    dly = recip_delta(diry);
    mx = cam_x >> 16;
    my = cam_y >> 16;
    frx = cam_x[15:0];
    fry = cam_y[15:0];
    if (dirx < 0) begin stx = -1; sdx = (frx * dlx) >> 16; end
    else begin stx = 1; sdx = ((65536 - frx) * dlx) >> 16; end
    if (diry < 0) begin sty = -1; sdy = (fry * dly) >> 16; end
    else begin sty = 1; sdy = ((65536 - fry) * dly) >> 16; end
    for (int n = 0; n < WALK_LIMIT; n++) begin
      if (sdx < sdy) begin
        sdx += dlx; mx += stx; side = 0;
      end else begin
        sdy += dly; my += sty; side = 1;
      end
      if (mx < 0 || mx >= GRID_WIDTH || my < 0 || my >= GRID_HEIGHT) begin
        left = 1'b1;
        break;
      end
      val = grid_cells[my * GRID_WIDTH + mx];
      if (val != 0) begin
        left = 1'b0;
        break;
      end
    end
    if (left) val = '0;
    perp = side ? sdy - dly : sdx - dlx;
    if (perp > 64'hFFFF_FFFF) perp = 64'hFFFF_FFFF;
    if (perp == 0) height = HEIGHT_CAP;
    else begin
      height = (longint'(SCREEN_HEIGHT) << 16) / perp;
      if (height > HEIGHT_CAP) height = HEIGHT_CAP;
    end
    half = height / 2;
    r.column = col;
    r.span_start = 9'(clamp_row(SCREEN_HEIGHT / 2 - half + horizon_q));
    r.span_end = 9'(clamp_row(SCREEN_HEIGHT / 2 + half + horizon_q));
    r.hit_side = side[0];
    r.left_map = left;
    r.wall_value = val;
    r.wall_x = 7'(mx);
    r.wall_y = 7'(my);
    r.perp = perp[31:0];
    return r;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [20:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      CFG_CAMERA_X: cam_x = data;
      CFG_CAMERA_Y: cam_y = data;
      CFG_VIEW_SINE: sine_q = data[15:0];
      CFG_VIEW_COSINE: cosine_q = data[15:0];
      CFG_HORIZON: horizon_q = data[13:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    while (expected_hits.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
  endtask

  task automatic send_beat(beat_row_t b, bit gaps);
    if (gaps && !quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_opcode <= b.opcode;
    in_column <= b.column;
    in_cell_x <= b.cx;
    in_cell_y <= b.cy;
    in_cell_value <= b.value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (b.opcode == OP_CAST) begin
      expected_hits.push_back(cast_column(b.column));
      typed_flag.push_back(b.typed);
      typed_start.push_back(b.span_start);
      typed_end.push_back(b.span_end);
    end else begin
      grid_cells[{b.cy, b.cx}] = b.value;
    end
    @(negedge clk);
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_hits.size() == 0) begin
        $error("column_echo: unexpected result %0d", out_column_echo);
        failures++;
      end else begin
        column_hit_t e;
        logic tf;
        logic [8:0] ts, te;
        e = expected_hits.pop_front();
        tf = typed_flag.pop_front();
        ts = typed_start.pop_front();
        te = typed_end.pop_front();
        if (tf && (ts != e.span_start || te != e.span_end)) begin
          $error("span_start/span_end table: expected %0d/%0d predictor %0d/%0d",
                 ts, te, e.span_start, e.span_end);
          failures++;
        end
        if (out_column_echo !== e.column) begin
          $error("column_echo: expected %0d actual %0d", e.column, out_column_echo);
          failures++;
        end
        if (out_span_start !== e.span_start) begin
          $error("span_start: expected %0d actual %0d", e.span_start, out_span_start);
          failures++;
        end
        if (out_span_end !== e.span_end) begin
          $error("span_end: expected %0d actual %0d", e.span_end, out_span_end);
          failures++;
        end
        if (out_hit_side !== e.hit_side) begin
          $error("hit_side: expected %0d actual %0d", e.hit_side, out_hit_side);
          failures++;
        end
        if (out_left_map !== e.left_map) begin
          $error("left_map: expected %0d actual %0d", e.left_map, out_left_map);
          failures++;
        end
        if (out_wall_value !== e.wall_value) begin
          $error("wall_value: expected %0d actual %0d", e.wall_value, out_wall_value);
          failures++;
        end
        if (out_wall_x !== e.wall_x) begin
          $error("wall_x: expected %0d actual %0d", e.wall_x, out_wall_x);
          failures++;
        end
        if (out_wall_y !== e.wall_y) begin
          $error("wall_y: expected %0d actual %0d", e.wall_y, out_wall_y);
          failures++;
        end
        if (out_perp_distance !== e.perp) begin
          $error("perp_distance: expected %h actual %h", e.perp, out_perp_distance);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("grid_raycast_column_top: mismatch");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (sink_active && !quiet) begin
      if (stall_left != 0) begin
        stall_left <= stall_left - 1;
      end else if (out_stall) begin
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        stall_left <= $urandom_range(0, 12);
      end
    end else begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end
  end

  beat_row_t directed [] = '{
    '{OP_CAST, 10'd320, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0},
    '{OP_CAST, 10'd0, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0},
    '{OP_CAST, 10'd639, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0},
    '{OP_CAST, 10'd1023, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0},
    '{OP_WRITE, 10'd0, 5'd16, 5'd17, 8'd255, 1'b0, 9'd0, 9'd0},
    '{OP_CAST, 10'd320, 5'd0, 5'd0, 8'd0, 1'b1, 9'd0, 9'd480},
    '{OP_WRITE, 10'd1023, 5'd31, 5'd31, 8'd1, 1'b0, 9'd0, 9'd0},
    '{OP_WRITE, 10'd0, 5'd0, 5'd0, 8'd170, 1'b0, 9'd0, 9'd0},
    '{OP_WRITE, 10'd0, 5'd16, 5'd20, 8'd85, 1'b0, 9'd0, 9'd0},
    '{OP_WRITE, 10'd0, 5'd16, 5'd17, 8'd0, 1'b0, 9'd0, 9'd0},
    '{OP_CAST, 10'd320, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0},
    '{OP_CAST, 10'd512, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0},
    '{OP_CAST, 10'd100, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0}
  };

  task automatic random_phase(int count, int fill);
    beat_row_t b;
    for (int i = 0; i < count; i++) begin
      b = '{default: '0};
      b.opcode = ($urandom_range(0, 99) < fill) ? OP_WRITE : OP_CAST;
      b.column = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 639));
      b.cx = 5'($urandom);
      b.cy = 5'($urandom);
      b.value = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'd0;
      send_beat(b, 1'b1);
    end
    end_burst();
  endtask

  initial begin
    for (int i = 0; i < MAP_DEPTH; i++) grid_cells[i] = '0;
    cam_x = 21'd1048576;
    cam_y = 21'd1048576;
    sine_q = '0;
    cosine_q = 16'sd16384;
    horizon_q = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    sink_active = 1'b1;
    foreach (directed[i]) send_beat(directed[i], 1'b0);
    end_burst();
    drain();
    write_reg(CFG_CAMERA_X, 21'd0);
    write_reg(CFG_CAMERA_Y, 21'h1F_FFFF);
    write_reg(CFG_VIEW_SINE, 21'(16'sd16384));
    write_reg(CFG_VIEW_COSINE, 21'(-16'sd16384));
    write_reg(CFG_HORIZON, 21'(14'sd4096));
    write_reg(3'd7, 21'h1F_FFFF);
    send_beat('{OP_CAST, 10'd320, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0}, 1'b0);
    send_beat('{OP_CAST, 10'd1023, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0}, 1'b0);
    end_burst();
    drain();
    write_reg(CFG_HORIZON, 21'(-14'sd4096));
    write_reg(CFG_VIEW_SINE, 21'(-16'sd16384));
    write_reg(CFG_VIEW_COSINE, 21'd0);
    write_reg(CFG_HORIZON, 21'(-14'sd4096));
    send_beat('{OP_CAST, 10'd320, 5'd0, 5'd0, 8'd0, 1'b0, 9'd0, 9'd0}, 1'b0);
    end_burst();
    drain();
    for (int phase = 0; phase < 6; phase++) begin
      write_reg(CFG_CAMERA_X, 21'($urandom_range(0, 34 << 16)));
      write_reg(CFG_CAMERA_Y, 21'($urandom_range(0, 34 << 16)));
      write_reg(CFG_VIEW_SINE, 21'(16'($signed($urandom_range(0, 32768)) - 16384)));
      write_reg(CFG_VIEW_COSINE, 21'(16'($signed($urandom_range(0, 32768)) - 16384)));
      write_reg(CFG_HORIZON, 21'(14'($signed($urandom_range(0, 8192)) - 4096)));
      if (phase == 5) quiet = 1'b1;
      random_phase(240, 45);
      drain();
    end
    if (failures == 0 && expected_hits.size() == 0)
      $display("grid_raycast_column_top: match");
    else
      $display("grid_raycast_column_top: mismatch");
    $finish;
  end

endmodule
